// ----- rtl/core/sapd_pkg.sv -----
package sapd_pkg;

  // Field and register widths.
  localparam int unsigned LevelW    = 16;
  localparam int unsigned ThreshW   = 16;
  localparam int unsigned WinW      = 9;
  localparam int unsigned MaxZonesW = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned StartW    = 20;
  localparam int unsigned EndW      = 21;
  localparam int unsigned CountW    = 16;

  // Delay line and window sum sizing.
  localparam int unsigned MaxWindow = 256;
  localparam int unsigned HistPtrW  = $clog2(MaxWindow);
  localparam int unsigned SumW      = LevelW + HistPtrW;
  localparam int unsigned LimitW    = ThreshW + WinW;

  // Frame index saturates at its largest value, all ones.
  localparam int unsigned FrameW    = StartW;
  localparam logic [FrameW-1:0] FrameMax = {FrameW{1'b1}};

  // Result queue sizing.
  localparam int unsigned ResDepth  = 4;
  localparam int unsigned ResPtrW   = $clog2(ResDepth);
  localparam int unsigned ResCntW   = ResPtrW + 1;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWindowLen = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxZones  = 2'd2;

  // Reset values of the registers.
  localparam logic [ThreshW-1:0]   ThresholdRst = 16'd1000;
  localparam logic [WinW-1:0]      WindowLenRst = 9'd16;
  localparam logic [MaxZonesW-1:0] MaxZonesRst  = 16'd64;

  // Result kinds.
  localparam logic KindZone    = 1'b0;
  localparam logic KindSummary = 1'b1;

  // One result item.
  typedef struct packed {
    logic              kind;
    logic [StartW-1:0] zone_start;
    logic [EndW-1:0]   zone_end;
    logic [CountW-1:0] zone_count;
    logic              end_mark;
  } result_t;

  // One item between the issue stage and the judging stage.
  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              last;
    logic              sub_old;
    logic              judge;
    logic [WinW-1:0]   win;
  } stage_t;

  // Window length clamped to 1 .. MaxWindow.
  function automatic logic [WinW-1:0] clamp_window(input logic [WinW-1:0] w);
    logic [WinW-1:0] r;
    if (w == '0) begin
      r = WinW'(1);
    end else if (w > WinW'(MaxWindow)) begin
      r = WinW'(MaxWindow);
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/sliding_average_pause_detector.sv -----
// Flow: an accepted item is registered in the judging stage; its results are then written into
// the result queue and offered from there.
// Throughput: one item per cycle while the four-entry result queue has room for two results
// of the item in the judging stage and two of the new item.
// Reset: asynchronous, active low; registers return to threshold 1000, window 16, 64 zones,
// and all stream state is cleared. The history memory is not cleared and needs no sweep.
module sliding_average_pause_detector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [sapd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [sapd_pkg::CfgDataW-1:0]    cfg_data_i,
  // Input channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sapd_pkg::LevelW-1:0]      level_i,
  input  logic                             last_i,
  // Output channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             kind_o,
  output logic [sapd_pkg::StartW-1:0]      zone_start_o,
  output logic [sapd_pkg::EndW-1:0]        zone_end_o,
  output logic [sapd_pkg::CountW-1:0]      zone_count_o,
  output logic                             end_mark_o
);
  import sapd_pkg::*;

  // Configuration registers.
  logic [ThreshW-1:0]   threshold_q;
  logic [WinW-1:0]      window_len_q;
  logic [MaxZonesW-1:0] max_zones_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= ThresholdRst;
      window_len_q <= WindowLenRst;
      max_zones_q  <= MaxZonesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgThreshold: threshold_q  <= cfg_data_i;
        CfgWindowLen: window_len_q <= cfg_data_i[WinW-1:0];
        CfgMaxZones:  max_zones_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshakes.
  logic in_accept;
  logic out_accept;

  assign in_accept  = in_valid_i & ~in_stall_o;
  assign out_accept = out_valid_o & ~out_stall_i;

  // Issue stage: delay line pointer, fill count and the latched window length.
  logic [HistPtrW-1:0] ptr_q;
  logic [WinW-1:0]     held_q;
  logic [WinW-1:0]     win_q;
  logic [WinW-1:0]     win_cur;
  logic                sub_old;
  logic [WinW-1:0]     held_inc;
  logic [HistPtrW-1:0] rd_addr;

  assign win_cur  = (held_q == '0) ? clamp_window(window_len_q) : win_q;
  assign sub_old  = (held_q >= win_cur);
  assign held_inc = sub_old ? held_q : held_q + WinW'(1);
  // A window of MaxWindow wraps onto the write address; the read then sees the old entry.
  assign rd_addr  = ptr_q - win_cur[HistPtrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      held_q <= '0;
      win_q  <= WindowLenRst;
    end else if (in_accept) begin
      win_q <= win_cur;
      if (last_i) begin
        ptr_q  <= '0;
        held_q <= '0;
      end else begin
        ptr_q  <= ptr_q + HistPtrW'(1);
        held_q <= held_inc;
      end
    end
  end

  // Level history: written at the pointer, the level leaving the window read in the same edge.
  logic [LevelW-1:0] hist_mem [MaxWindow];
  logic [LevelW-1:0] old_level_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      hist_mem[ptr_q] <= level_i;
      old_level_q     <= hist_mem[rd_addr];
    end
  end

  // Judging stage register.
  logic   s1_valid_q;
  stage_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q.level   <= level_i;
      s1_q.last    <= last_i;
      s1_q.sub_old <= sub_old;
      s1_q.judge   <= (held_inc >= win_cur);
      s1_q.win     <= win_cur;
    end
  end

  // Stream state.
  logic [SumW-1:0]      sum_q;
  logic [FrameW-1:0]    frame_q;
  logic                 in_pause_q;
  logic [StartW-1:0]    pause_begin_q;
  logic [CountW-1:0]    zones_q;

  // Window sum and quiet decision.
  logic [SumW-1:0]   sum_d;
  logic [LimitW-1:0] limit;
  logic              quiet;
  logic [EndW-1:0]   frame_next;
  logic [StartW-1:0] win_start;
  logic              emit_zone;
  logic [CountW-1:0] zones_inc;

  assign sum_d = sum_q - (s1_q.sub_old ? SumW'(old_level_q) : '0) + SumW'(s1_q.level);
  assign limit = LimitW'(threshold_q) * LimitW'(s1_q.win);
  assign quiet = (LimitW'(sum_d) < limit);

  assign frame_next = EndW'(frame_q) + EndW'(1);
  assign win_start  = (frame_next >= EndW'(s1_q.win))
                    ? StartW'(frame_next - EndW'(s1_q.win)) : '0;
  assign emit_zone  = s1_valid_q & s1_q.judge & ~quiet & in_pause_q & (zones_q < max_zones_q);
  assign zones_inc  = zones_q + CountW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q         <= '0;
      frame_q       <= '0;
      in_pause_q    <= 1'b0;
      pause_begin_q <= '0;
      zones_q       <= '0;
    end else if (s1_valid_q) begin
      if (s1_q.last) begin
        sum_q         <= '0;
        frame_q       <= '0;
        in_pause_q    <= 1'b0;
        pause_begin_q <= '0;
        zones_q       <= '0;
      end else begin
        sum_q <= sum_d;
        if (frame_q != FrameMax) begin
          frame_q <= frame_q + FrameW'(1);
        end
        if (s1_q.judge) begin
          in_pause_q <= quiet;
          if (quiet && !in_pause_q) begin
            pause_begin_q <= win_start;
          end
        end
        if (emit_zone) begin
          zones_q <= zones_inc;
        end
      end
    end
  end

  // Results of the item in the judging stage.
  result_t zone_res;
  result_t sum_res;
  result_t push_first;
  logic    push_one;
  logic    push_two;

  always_comb begin
    zone_res.kind       = KindZone;
    zone_res.zone_start = pause_begin_q;
    zone_res.zone_end   = frame_next;
    zone_res.zone_count = zones_inc;
    zone_res.end_mark   = 1'b0;

    sum_res.kind        = KindSummary;
    sum_res.zone_start  = '0;
    sum_res.zone_end    = '0;
    sum_res.zone_count  = emit_zone ? zones_inc : zones_q;
    sum_res.end_mark    = 1'b1;
  end

  assign push_first = emit_zone ? zone_res : sum_res;
  assign push_one   = emit_zone | (s1_valid_q & s1_q.last);
  assign push_two   = emit_zone & s1_q.last;

  // Result queue.
  result_t             res_mem [ResDepth];
  logic [ResPtrW-1:0]  res_wp_q;
  logic [ResPtrW-1:0]  res_rp_q;
  logic [ResCntW-1:0]  res_cnt_q;
  logic [ResCntW-1:0]  push_cnt;
  logic [ResCntW:0]    room_need;

  assign push_cnt = ResCntW'(push_one) + ResCntW'(push_two);

  always_ff @(posedge clk_i) begin
    if (push_one) begin
      res_mem[res_wp_q] <= push_first;
    end
    if (push_two) begin
      res_mem[res_wp_q + ResPtrW'(1)] <= sum_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wp_q  <= '0;
      res_rp_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      res_wp_q  <= res_wp_q + ResPtrW'(push_cnt);
      if (out_accept) begin
        res_rp_q <= res_rp_q + ResPtrW'(1);
      end
      res_cnt_q <= res_cnt_q + push_cnt - ResCntW'(out_accept);
    end
  end

  // Take a new item only if the queue can hold two results of it and of the judging stage.
  assign room_need  = (ResCntW+1)'(res_cnt_q) + (s1_valid_q ? (ResCntW+1)'(2) : '0);
  assign in_stall_o = (room_need > (ResCntW+1)'(ResDepth - 2));

  // Output channel.
  assign out_valid_o  = (res_cnt_q != '0);
  assign kind_o       = res_mem[res_rp_q].kind;
  assign zone_start_o = res_mem[res_rp_q].zone_start;
  assign zone_end_o   = res_mem[res_rp_q].zone_end;
  assign zone_count_o = res_mem[res_rp_q].zone_count;
  assign end_mark_o   = res_mem[res_rp_q].end_mark;

endmodule

// ----- rtl/core/sapd_checker.sv -----
module sapd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic        kind_i,
  input logic [19:0] zone_start_i,
  input logic [20:0] zone_end_i,
  input logic        end_mark_i
);

  // An offered item stays offered while it is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("output item withdrawn while stalled");

  // The end mark appears exactly on summary items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (kind_i == end_mark_i))
    else $error("end mark does not match item kind");

  // A summary item carries no zone bounds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i |-> (zone_start_i == '0) && (zone_end_i == '0))
    else $error("summary item carries zone bounds");

  // A zone always ends after it starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !kind_i |-> (zone_end_i > {1'b0, zone_start_i}))
    else $error("zone end not after zone start");

endmodule

bind sliding_average_pause_detector sapd_checker u_sapd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .kind_i       (kind_o),
  .zone_start_i (zone_start_o),
  .zone_end_i   (zone_end_o),
  .end_mark_i   (end_mark_o)
);
